// File: rtl/i2cbe_pkg.sv
// Package for the I2C master bit engine: codes, item types and the phase decode.
package i2cbe_pkg;

  // Command codes carried in func
  localparam logic [2:0] FUNC_START = 3'd0;
  localparam logic [2:0] FUNC_STOP  = 3'd1;
  localparam logic [2:0] FUNC_SEND  = 3'd2;
  localparam logic [2:0] FUNC_RECV  = 3'd3;
  localparam logic [2:0] FUNC_SACK  = 3'd4;
  localparam logic [2:0] FUNC_RACK  = 3'd5;

  // Line action taken on the first tick of a phase
  localparam logic [2:0] ACT_SDA_LO     = 3'd0;
  localparam logic [2:0] ACT_SDA_HI     = 3'd1;
  localparam logic [2:0] ACT_SDA_TX     = 3'd2;
  localparam logic [2:0] ACT_SCL_HI     = 3'd3;
  localparam logic [2:0] ACT_SCL_LO     = 3'd4;
  localparam logic [2:0] ACT_SAMPLE_BIT = 3'd5;
  localparam logic [2:0] ACT_SAMPLE_ACK = 3'd6;

  localparam int unsigned PLEN_W  = 16;
  localparam int unsigned PHASE_W = 5;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] bit_idx;  // 0 selects the MSB
  } action_t;

  typedef struct packed {
    logic       sda_sample;
    logic       ack_to_send;
    logic [7:0] tx_byte;
    logic [2:0] func;
    logic       cmd_valid;
  } in_item_t;

  typedef struct packed {
    logic       ack_received;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_level;
    logic       scl_level;
  } result_t;

  function automatic logic [PHASE_W-1:0] phase_count(input logic [2:0] cmd);
    logic [PHASE_W-1:0] n;
    case (cmd)
      FUNC_START: n = 5'd4;
      FUNC_STOP:  n = 5'd3;
      FUNC_SEND:  n = 5'd24;
      FUNC_RECV:  n = 5'd25;
      FUNC_SACK:  n = 5'd3;
      default:    n = 5'd4;
    endcase
    return n;
  endfunction

  // p / 3 for p below 32 as (p * 11) >> 5, exact over that range
  function automatic logic [3:0] div3(input logic [PHASE_W-1:0] p);
    logic [8:0] m;
    m = {4'b0, p} * 9'd11;
    return m[8:5];
  endfunction

  function automatic action_t phase_action(input logic [2:0] cmd,
                                           input logic [PHASE_W-1:0] p);
    action_t            a;
    logic [PHASE_W-1:0] pm1;
    logic [3:0]         d;
    logic [PHASE_W-1:0] q;
    pm1 = p - 5'd1;
    d   = 4'd0;
    q   = 5'd0;
    a.bit_idx = 3'd0;
    a.op      = ACT_SCL_LO;
    case (cmd)
      FUNC_START: begin
        case (p)
          5'd0:    a.op = ACT_SDA_HI;
          5'd1:    a.op = ACT_SCL_HI;
          5'd2:    a.op = ACT_SDA_LO;
          default: a.op = ACT_SCL_LO;
        endcase
      end
      FUNC_STOP: begin
        case (p)
          5'd0:    a.op = ACT_SDA_LO;
          5'd1:    a.op = ACT_SCL_HI;
          default: a.op = ACT_SDA_HI;
        endcase
      end
      FUNC_SEND: begin
        d = div3(p);
        q = p - ({d, 1'b0} + {1'b0, d});
        a.bit_idx = d[2:0];
        case (q[1:0])
          2'd0:    a.op = ACT_SDA_TX;
          2'd1:    a.op = ACT_SCL_HI;
          default: a.op = ACT_SCL_LO;
        endcase
      end
      FUNC_RECV: begin
        d = div3(pm1);
        q = pm1 - ({d, 1'b0} + {1'b0, d});
        a.bit_idx = d[2:0];
        if (p == 5'd0) begin
          a.op = ACT_SDA_HI;
        end else begin
          case (q[1:0])
            2'd0:    a.op = ACT_SCL_HI;
            2'd1:    a.op = ACT_SAMPLE_BIT;
            default: a.op = ACT_SCL_LO;
          endcase
        end
      end
      FUNC_SACK: begin
        a.bit_idx = 3'd7;  // ack level sits in bit 0 of the hold register
        case (p)
          5'd0:    a.op = ACT_SDA_TX;
          5'd1:    a.op = ACT_SCL_HI;
          default: a.op = ACT_SCL_LO;
        endcase
      end
      default: begin
        case (p)
          5'd0:    a.op = ACT_SDA_HI;
          5'd1:    a.op = ACT_SCL_HI;
          5'd2:    a.op = ACT_SAMPLE_ACK;
          default: a.op = ACT_SCL_LO;
        endcase
      end
    endcase
    return a;
  endfunction

endpackage

// File: rtl/i2cbe_core.sv
// Sequencer state and per-tick update of the I2C master bit engine.
module i2cbe_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  i2cbe_pkg::in_item_t             item,
  input  logic [i2cbe_pkg::PLEN_W-1:0]    phase_length,
  output i2cbe_pkg::result_t              res
);

  logic                             scl_reg, scl_reg_next;
  logic                             sda_reg, sda_reg_next;
  logic [2:0]                       active_command, active_command_next;
  logic                             busy_flag, busy_flag_next;
  logic [i2cbe_pkg::PHASE_W-1:0]    phase_index, phase_index_next;
  logic [i2cbe_pkg::PLEN_W-1:0]     tick_count, tick_count_next;
  logic [7:0]                       shift_reg, shift_reg_next;
  logic                             ack_reg, ack_reg_next;
  logic [7:0]                       tx_hold, tx_hold_next;

  logic                             start;
  logic [2:0]                       cmd;
  logic                             busy_now;
  logic [i2cbe_pkg::PHASE_W-1:0]    pidx;
  logic [i2cbe_pkg::PLEN_W-1:0]     tcnt;
  logic [i2cbe_pkg::PLEN_W-1:0]     plen;
  logic [i2cbe_pkg::PLEN_W:0]       tcnt_inc;
  logic                             phase_end;
  logic                             last_phase;
  logic                             done;
  logic [7:0]                       bit_mask;
  i2cbe_pkg::action_t               act;

  always_comb begin
    start = !busy_flag && item.cmd_valid && (item.func <= i2cbe_pkg::FUNC_RACK);
    cmd      = start ? item.func : active_command;
    busy_now = busy_flag || start;
    pidx     = start ? '0 : phase_index;
    tcnt     = start ? '0 : tick_count;
    plen     = (phase_length == '0) ? {{(i2cbe_pkg::PLEN_W-1){1'b0}}, 1'b1} : phase_length;

    tx_hold_next = tx_hold;
    if (start && item.func == i2cbe_pkg::FUNC_SEND) begin
      tx_hold_next = item.tx_byte;
    end else if (start && item.func == i2cbe_pkg::FUNC_SACK) begin
      tx_hold_next = {7'b0, item.ack_to_send};
    end
    shift_reg_next = (start && item.func == i2cbe_pkg::FUNC_RECV) ? 8'h00 : shift_reg;

    act      = i2cbe_pkg::phase_action(cmd, pidx);
    bit_mask = 8'h80 >> act.bit_idx;

    scl_reg_next = scl_reg;
    sda_reg_next = sda_reg;
    ack_reg_next = ack_reg;
    if (busy_now && tcnt == '0) begin
      case (act.op)
        i2cbe_pkg::ACT_SDA_LO:     sda_reg_next = 1'b0;
        i2cbe_pkg::ACT_SDA_HI:     sda_reg_next = 1'b1;
        i2cbe_pkg::ACT_SDA_TX:     sda_reg_next = |(tx_hold_next & bit_mask);
        i2cbe_pkg::ACT_SCL_HI:     scl_reg_next = 1'b1;
        i2cbe_pkg::ACT_SCL_LO:     scl_reg_next = 1'b0;
        i2cbe_pkg::ACT_SAMPLE_BIT: begin
          if (item.sda_sample) shift_reg_next = shift_reg_next | bit_mask;
        end
        i2cbe_pkg::ACT_SAMPLE_ACK: ack_reg_next = item.sda_sample;
        default:                   scl_reg_next = scl_reg;
      endcase
    end

    tcnt_inc   = {1'b0, tcnt} + 17'd1;
    phase_end  = tcnt_inc >= {1'b0, plen};
    last_phase = (pidx + 5'd1) >= i2cbe_pkg::phase_count(cmd);
    done       = busy_now && phase_end && last_phase;

    active_command_next = cmd;
    busy_flag_next      = busy_now && !done;
    phase_index_next    = pidx;
    tick_count_next     = tcnt;
    if (busy_now) begin
      if (phase_end) begin
        tick_count_next  = '0;
        phase_index_next = last_phase ? '0 : pidx + 5'd1;
      end else begin
        tick_count_next  = tcnt_inc[i2cbe_pkg::PLEN_W-1:0];
      end
    end

    res.scl_level    = scl_reg_next;
    res.sda_level    = sda_reg_next;
    res.busy_res     = busy_now;
    res.done_res     = done;
    res.rx_byte      = shift_reg_next;
    res.ack_received = ack_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl_reg        <= 1'b1;
      sda_reg        <= 1'b1;
      active_command <= i2cbe_pkg::FUNC_START;
      busy_flag      <= 1'b0;
      phase_index    <= '0;
      tick_count     <= '0;
      shift_reg      <= 8'h00;
      ack_reg        <= 1'b0;
      tx_hold        <= 8'h00;
    end else if (en) begin
      scl_reg        <= scl_reg_next;
      sda_reg        <= sda_reg_next;
      active_command <= active_command_next;
      busy_flag      <= busy_flag_next;
      phase_index    <= phase_index_next;
      tick_count     <= tick_count_next;
      shift_reg      <= shift_reg_next;
      ack_reg        <= ack_reg_next;
      tx_hold        <= tx_hold_next;
    end
  end

endmodule

// File: rtl/i2c_master_bit_engine.sv
// I2C master bit engine top level: stream ports, input and result registers.
//
// Each input item is one bus tick carrying the sampled SDA level and an
// optional command (start, stop, send byte, receive byte, send ack, receive
// ack). Every item yields exactly one result item with the SCL/SDA drive
// levels after that tick (1 = released), busy, a done pulse on the tick the
// command's last phase ends, the received byte and the received ack. A
// command that arrives while busy, including on the done tick, or with an
// unknown code is dropped. Each bus phase lasts phase_length ticks (0 acts
// as 1); line writes and SDA samples happen on a phase's first tick.
// Throughput is one item per clock while the result side is not stalled:
// the item is taken into an input register, one pass of sequencer logic
// updates the state and fills the result register, which drives m_tvalid.
// s_tready follows m_tready combinationally while both registers are full,
// so a stall on the result side holds at most one item in each of the two
// registers.
// phase_length may only be rewritten while no item is in flight.
module i2c_master_bit_engine (
  input  logic        clk,
  input  logic        rst,
  // configuration: phase_length
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // tx_byte[7:0], ack_to_send[8], sda_sample[9], zero pad
  input  logic [3:0]  s_tuser,   // cmd_valid[0], func[3:1]
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // scl_level[0], sda_level[1], busy_res[2], done_res[3],
                                 // rx_byte[11:4], ack_received[12], zero pad
);

  logic [i2cbe_pkg::PLEN_W-1:0] phase_length;

  logic                 in_vld;
  i2cbe_pkg::in_item_t  in_item;
  logic                 out_vld;
  i2cbe_pkg::result_t   out_res;
  i2cbe_pkg::result_t   core_res;
  logic                 adv;

  // the held item moves on when the result register is free or draining
  assign adv      = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || adv;
  assign m_tvalid = out_vld;
  assign m_tdata  = {3'b000, out_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_length <= 16'd1;
    end else if (cfg_we) begin
      phase_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.cmd_valid   <= s_tuser[0];
      in_item.func        <= s_tuser[3:1];
      in_item.tx_byte     <= s_tdata[7:0];
      in_item.ack_to_send <= s_tdata[8];
      in_item.sda_sample  <= s_tdata[9];
    end
  end

  i2cbe_core u_core (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .item         (in_item),
    .phase_length (phase_length),
    .res          (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= core_res;
    end
  end

`ifndef ASSERT_OFF
  // a done pulse only ends a running sequence
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[3] || m_tdata[2]))
    else $error("done without busy");

  // an item advancing out of the input register always lands in the result register
  a_adv_lands: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_vld)
    else $error("advanced item lost");

  // with nothing held at the input, a new item is always taken
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !in_vld |-> s_tready)
    else $error("input stalled while empty");
`endif

endmodule

// File: tb/i2c_bus_checker.sv
// Checker for the I2C master bit engine: predicts every tick's result and compares.
module i2c_bus_checker
  import i2cbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [3:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  output int          mismatch_count,
  output int          results_due,
  output logic        engine_busy,
  output int          cmds_started,
  output int          cmds_done,
  output int          ticks_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] phase_len;
  logic        scl_q;
  logic        sda_q;
  logic        ack_q;
  logic [2:0]  cur_cmd;
  logic [4:0]  phase;
  logic [15:0] tick_in_phase;
  logic [7:0]  rx_q;
  logic [7:0]  tx_q;
  result_t     bus_results_due[$];

  function automatic int phases_in(input logic [2:0] cmd);
    int n;
    case (cmd)
      FUNC_START: n = 4;
      FUNC_STOP:  n = 3;
      FUNC_SEND:  n = 24;
      FUNC_RECV:  n = 25;
      FUNC_SACK:  n = 3;
      default:    n = 4;
    endcase
    return n;
  endfunction

  // line write or SDA sample on the first tick of a phase
  task automatic do_phase(input logic sda_in);
    int k;
    case (cur_cmd)
      FUNC_START: begin
        case (phase)
          5'd0:    sda_q = 1'b1;
          5'd1:    scl_q = 1'b1;
          5'd2:    sda_q = 1'b0;
          default: scl_q = 1'b0;
        endcase
      end
      FUNC_STOP: begin
        case (phase)
          5'd0:    sda_q = 1'b0;
          5'd1:    scl_q = 1'b1;
          default: sda_q = 1'b1;
        endcase
      end
      FUNC_SEND: begin
        k = int'(phase);
        case (k % 3)
          0:       sda_q = tx_q[7 - k / 3];
          1:       scl_q = 1'b1;
          default: scl_q = 1'b0;
        endcase
      end
      FUNC_RECV: begin
        k = int'(phase) - 1;
        if (phase == 5'd0) begin
          sda_q = 1'b1;
        end else begin
          case (k % 3)
            0:       scl_q = 1'b1;
            1:       if (sda_in) rx_q[7 - k / 3] = 1'b1;
            default: scl_q = 1'b0;
          endcase
        end
      end
      FUNC_SACK: begin
        case (phase)
          5'd0:    sda_q = tx_q[0];
          5'd1:    scl_q = 1'b1;
          default: scl_q = 1'b0;
        endcase
      end
      default: begin
        case (phase)
          5'd0:    sda_q = 1'b1;
          5'd1:    scl_q = 1'b1;
          5'd2:    ack_q = sda_in;
          default: scl_q = 1'b0;
        endcase
      end
    endcase
  endtask

  task automatic advance_tick(input logic cv, input logic [2:0] func, input logic [7:0] tx,
                              input logic ack, input logic sda_in, output result_t r);
    logic [16:0] len;
    len = (phase_len == 16'd0) ? 17'd1 : {1'b0, phase_len};
    r = '0;
    // commands are dropped while busy, done tick included
    if (!engine_busy && cv && func <= FUNC_RACK) begin
      cur_cmd       = func;
      engine_busy   = 1'b1;
      phase         = '0;
      tick_in_phase = '0;
      if (func == FUNC_SEND) tx_q = tx;
      else if (func == FUNC_SACK) tx_q = {7'd0, ack};
      if (func == FUNC_RECV) rx_q = '0;
      cmds_started++;
    end
    if (engine_busy) begin
      r.busy_res = 1'b1;
      if (tick_in_phase == 16'd0) do_phase(sda_in);
      if ({1'b0, tick_in_phase} + 17'd1 >= len) begin
        tick_in_phase = '0;
        if (int'(phase) + 1 >= phases_in(cur_cmd)) begin
          r.done_res  = 1'b1;
          engine_busy = 1'b0;
          phase       = '0;
          cmds_done++;
        end else begin
          phase = phase + 5'd1;
        end
      end else begin
        tick_in_phase = tick_in_phase + 16'd1;
      end
    end
    r.scl_level    = scl_q;
    r.sda_level    = sda_q;
    r.rx_byte      = rx_q;
    r.ack_received = ack_q;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    result_t next_res;
    if (rst) begin
      phase_len     = 16'd1;
      scl_q         = 1'b1;
      sda_q         = 1'b1;
      ack_q         = 1'b0;
      cur_cmd       = FUNC_START;
      engine_busy   = 1'b0;
      phase         = '0;
      tick_in_phase = '0;
      rx_q          = '0;
      tx_q          = '0;
      bus_results_due.delete();
    end else begin
      // compare first so a stray result never meets this edge's prediction
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[12:0]);
        if (bus_results_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with nothing expected, got %0h", $time, m_tdata);
        end else begin
          want = bus_results_due.pop_front();
          check_field("scl_level", want.scl_level, got.scl_level);
          check_field("sda_level", want.sda_level, got.sda_level);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          check_field("rx_byte", want.rx_byte, got.rx_byte);
          check_field("ack_received", want.ack_received, got.ack_received);
        end
      end
      if (cfg_we) phase_len = cfg_data;
      if (s_tvalid && s_tready) begin
        advance_tick(s_tuser[0], s_tuser[3:1], s_tdata[7:0], s_tdata[8], s_tdata[9], next_res);
        bus_results_due.push_back(next_res);
        ticks_seen++;
      end
    end
    results_due = bus_results_due.size();
  end

endmodule

// File: tb/i2c_master_bit_engine_tb.sv
// Testbench top for the I2C master bit engine: clock, reset, tick stimulus and verdict.
module i2c_master_bit_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cbe_pkg::*;

  // codes outside the command set, must be dropped
  localparam logic [2:0] FUNC_BAD6 = 3'd6;
  localparam logic [2:0] FUNC_BAD7 = 3'd7;

  // SDA level driven while waiting to issue a command
  localparam int SDA_LO   = 0;
  localparam int SDA_HI   = 1;
  localparam int SDA_RAND = 2;

  localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
  localparam int HOLD_OFF    = 80;    // long receiver stall for back-pressure

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // tx_byte[7:0], ack_to_send[8], sda_sample[9], zero pad
  logic [3:0]  s_tuser;   // cmd_valid[0], func[3:1]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // scl_level[0], sda_level[1], busy_res[2], done_res[3],
                          // rx_byte[11:4], ack_received[12], zero pad

  int          mismatch_count;
  int          results_due;
  logic        engine_busy;
  int          cmds_started;
  int          cmds_done;
  int          ticks_seen;

  int          send_idle;    // percent of offers preceded by a gap
  int          recv_idle;    // percent of cycles with m_tready low
  int          rx_hold_len;  // nonzero asks the receiver for one long stall
  int          idle_cycles;
  logic [2:0]  last_func;    // last command that actually started

  i2c_master_bit_engine u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  i2c_bus_checker u_chk (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (mismatch_count),
    .results_due    (results_due),
    .engine_busy    (engine_busy),
    .cmds_started   (cmds_started),
    .cmds_done      (cmds_done),
    .ticks_seen     (ticks_seen)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random m_tready at the falling edge; a requested hold-off keeps
  // it low for a counted stretch so the block backs up into s_tready.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_len > 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold_len) @(negedge clk);
        rx_hold_len = 0;
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles at %0t", idle_cycles, $time);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One tick item: optional gap, offer, hold until taken, return at the next
  // falling edge. Content stays stable while the offer waits.
  task automatic put_item(input logic cv, input logic [2:0] func, input logic [7:0] tx,
                          input logic ack, input logic sda);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {func, cv};
    s_tdata  <= {6'd0, sda, ack, tx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Keep offering the command every tick until the engine takes it. While the
  // previous command runs these offers are dropped, done tick included.
  task automatic issue_cmd(input logic [2:0] func, input logic [7:0] tx, input logic ack,
                           input int sda_mode);
    int start_cnt;
    start_cnt = cmds_started;
    while (cmds_started == start_cnt)
      put_item(1'b1, func, tx, ack,
               (sda_mode == SDA_RAND) ? 1'($urandom_range(1)) : sda_mode[0]);
    last_func = func;
  endtask

  // Plain ticks until the running sequence, if any, has ended.
  task automatic drain_engine();
    while (engine_busy)
      put_item(1'b0, FUNC_START, 8'h00, 1'b0, 1'($urandom_range(1)));
  endtask

  // Next command of a well-formed transfer: start, address/data bytes each
  // followed by an ack, reads acked by the master, then stop.
  function automatic logic [2:0] next_in_flow(input logic [2:0] prev);
    logic [2:0] f;
    case (prev)
      FUNC_START: f = FUNC_SEND;
      FUNC_SEND:  f = FUNC_RACK;
      FUNC_RECV:  f = FUNC_SACK;
      FUNC_RACK: begin
        case ($urandom_range(2))
          0:       f = FUNC_SEND;
          1:       f = FUNC_RECV;
          default: f = FUNC_STOP;
        endcase
      end
      FUNC_SACK:  f = $urandom_range(1) ? FUNC_RECV : FUNC_STOP;
      default:    f = FUNC_START;
    endcase
    return f;
  endfunction

  // Random ticks: mostly well-formed transfers issued when the engine is idle,
  // with some broken order, unknown codes and commands thrown in while busy.
  task automatic run_random(input int n);
    logic [2:0] f;
    logic       cv;
    int         start_cnt;
    repeat (n) begin
      start_cnt = cmds_started;
      f  = 3'($urandom_range(7));
      cv = 1'b0;
      if (!engine_busy && $urandom_range(99) < 75) begin
        cv = 1'b1;
        if ($urandom_range(99) >= 10) f = next_in_flow(last_func);
      end else if ($urandom_range(99) < 8) begin
        cv = 1'b1;
      end
      put_item(cv, f, 8'($urandom), 1'($urandom), 1'($urandom));
      if (cmds_started != start_cnt) last_func = f;
    end
  endtask

  // Register write with nothing in flight; the engine itself may be mid-phase.
  task automatic set_phase_len(input logic [15:0] v);
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    send_idle   = 30;
    recv_idle   = 55;
    rx_hold_len = 0;
    last_func   = FUNC_STOP;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset phase length: unknown codes while idle, then every
    // command with byte and ack extremes. The SDA level chosen for each step
    // is what the previous command samples while this one waits.
    put_item(1'b1, FUNC_BAD7, 8'hFF, 1'b1, 1'b1);
    put_item(1'b1, FUNC_BAD6, 8'h00, 1'b0, 1'b0);
    issue_cmd(FUNC_START, 8'h00, 1'b0, SDA_RAND);
    issue_cmd(FUNC_SEND,  8'hFF, 1'b0, SDA_RAND);
    issue_cmd(FUNC_RACK,  8'h00, 1'b0, SDA_RAND);
    issue_cmd(FUNC_SEND,  8'h00, 1'b1, SDA_LO);    // ack seen as 0
    issue_cmd(FUNC_RACK,  8'hFF, 1'b1, SDA_RAND);
    issue_cmd(FUNC_RECV,  8'h00, 1'b0, SDA_HI);    // ack seen as 1
    issue_cmd(FUNC_SACK,  8'h00, 1'b1, SDA_HI);    // byte reads 0xFF
    issue_cmd(FUNC_RECV,  8'hFF, 1'b1, SDA_RAND);
    issue_cmd(FUNC_SACK,  8'hFF, 1'b0, SDA_LO);    // byte reads 0x00
    issue_cmd(FUNC_STOP,  8'h00, 1'b0, SDA_RAND);

    // zero length acts as one tick per phase
    set_phase_len(16'd0);
    run_random(40);
    drain_engine();

    // longest phases, then shorten mid phase so the phase ends at once
    set_phase_len(16'hFFFF);
    issue_cmd(FUNC_START, 8'($urandom), 1'($urandom), SDA_RAND);
    run_random(30);
    set_phase_len(16'd3);
    run_random(100);

    // swap the idling sides
    send_idle = 55;
    recv_idle = 30;
    set_phase_len(16'd2);
    run_random(100);

    // no idling, with one long receiver hold-off while items keep coming
    send_idle = 0;
    recv_idle = 0;
    set_phase_len(16'd1);
    run_random(60);
    rx_hold_len = HOLD_OFF;
    run_random(100);

    s_tvalid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d ticks, %0d commands taken, %0d completed", ticks_seen,
             cmds_started, cmds_done);
    $display("phase lengths 0/1/2/3/65535 incl. mid-phase change, busy and unknown codes");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
